// ===== rtl/core/pwm_channel_fuse_fade_controller_defines.svh =====
// ----------------------------------------------------------------------------
// PWM channel fuse and fade controller: assertion macros
// Shared concurrent assertion forms used by the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef PWM_CHANNEL_FUSE_FADE_CONTROLLER_DEFINES_SVH
`define PWM_CHANNEL_FUSE_FADE_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfc: next-cycle check failed");

`endif

// ===== rtl/core/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM channel fuse and fade controller package
// Field widths, command codes, register indexes and control structs.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int CUR_W      = 16;
    localparam int FADE_MS_W  = 16;
    localparam int TIME_W     = 17;
    localparam int TRIP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CUR_W-1:0] FUSE_RESET_MA = 16'd20000;

    typedef enum logic [1:0] {
        ACT_TICK       = 2'd0,
        ACT_SET_DUTY   = 2'd1,
        ACT_START_FADE = 2'd2,
        ACT_SET_SWITCH = 2'd3
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMMABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_FUSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_LIM  = 2'd2;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic finish;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic interp;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/pfc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfc_cfg_if
    import pfc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pfc_in_if.sv =====
// ----------------------------------------------------------------------------
// Input item channel
// One command or tick per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfc_in_if
    import pfc_pkg::*;
#(
    parameter int DUTY_W = 13
) ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [CUR_W-1:0]     current_ma;
    logic [DUTY_W-1:0]    duty_level;
    logic [FADE_MS_W-1:0] fade_ms;
    logic                 switch_on;

    modport source (output valid, output action, output current_ma, output duty_level,
                    output fade_ms, output switch_on, input ready);
    modport sink   (input valid, input action, input current_ma, input duty_level,
                    input fade_ms, input switch_on, output ready);
endinterface

// ===== rtl/core/pfc_out_if.sv =====
// ----------------------------------------------------------------------------
// Result item channel
// Compare level and channel state, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfc_out_if
    import pfc_pkg::*;
#(
    parameter int DUTY_W = 13
) ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] pwm_level;
    logic [DUTY_W-1:0] duty_now;
    logic              channel_on;
    logic              fuse_tripped;
    logic              fade_busy;
    logic [TRIP_W-1:0] trip_total;

    modport source (output valid, output pwm_level, output duty_now, output channel_on,
                    output fuse_tripped, output fade_busy, output trip_total, input ready);
    modport sink   (input valid, input pwm_level, input duty_now, input channel_on,
                    input fuse_tripped, input fade_busy, input trip_total, output ready);
endinterface

// ===== rtl/core/pfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// PWM channel controller state machine
// Sequences accept, fade interpolation multiply, serial divide and result.
// ----------------------------------------------------------------------------
`include "pwm_channel_fuse_fade_controller_defines.svh"

module pfc_ctrl
    import pfc_pkg::*;
#(
    parameter int DUTY_BITS = 12
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);
    localparam int DW    = DUTY_BITS + 1;
    localparam int PW    = TIME_W + DW + 1;
    localparam int CNT_W = $clog2(PW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish   = (r_state == S_FIN);
        o_cmd.emit     = (r_state == S_EMIT) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= i_stat.interp ? S_MUL : S_EMIT;
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(PW - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // Wait here until the output register can take the result.
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PFC_ASSERT_NEXT(a_no_accept_after_load, i_clk, i_rst_n, o_cmd.load, !o_in_ready)
    `PFC_ASSERT_IMPL(a_fin_after_all_steps, i_clk, i_rst_n, r_state == S_FIN, r_cnt == CNT_W'(PW))
    `PFC_ASSERT_IMPL(a_mul_needs_interp, i_clk, i_rst_n, r_state == S_MUL, $past(i_stat.interp))

endmodule

// ===== rtl/core/pfc_datapath.sv =====
// ----------------------------------------------------------------------------
// PWM channel datapath
// Channel state, fuse check, fade multiply and restoring divider, result register.
// ----------------------------------------------------------------------------
`include "pwm_channel_fuse_fade_controller_defines.svh"

module pfc_datapath
    import pfc_pkg::*;
#(
    parameter int DUTY_BITS   = 12,
    parameter int FADE_PAD_MS = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_action,
    input  logic [CUR_W-1:0]      i_current_ma,
    input  logic [DUTY_BITS:0]    i_duty_level,
    input  logic [FADE_MS_W-1:0]  i_fade_ms,
    input  logic                  i_switch_on,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [DUTY_BITS:0]    o_pwm_level,
    output logic [DUTY_BITS:0]    o_duty_now,
    output logic                  o_channel_on,
    output logic                  o_fuse_tripped,
    output logic                  o_fade_busy,
    output logic [TRIP_W-1:0]     o_trip_total
);
    localparam int DW = DUTY_BITS + 1;
    localparam int MW = TIME_W + DW;
    localparam int PW = MW + 1;
    localparam logic [DW-1:0]     FULL_SCALE = DW'(1) << DUTY_BITS;
    localparam logic [TIME_W-1:0] PAD        = TIME_W'(FADE_PAD_MS);

    // Configuration
    logic              r_dimmable;
    logic [CUR_W-1:0]  r_fuse_ma;
    logic [CUR_W-1:0]  r_board_ma;

    // Channel state
    logic [DW-1:0]     r_duty;
    logic              r_on;
    logic              r_trip;
    logic [TRIP_W-1:0] r_trip_cnt;
    logic              r_fade_active;
    logic [DW-1:0]     r_from;
    logic [DW-1:0]     r_to;
    logic [TIME_W-1:0] r_elapsed;
    logic [TIME_W-1:0] r_total;
    logic              r_interp;

    // Interpolation unit
    logic              r_up;
    logic [PW-1:0]     r_quo;
    logic [TIME_W-1:0] r_rem;

    // Result register
    logic              r_out_valid;
    logic [DW-1:0]     r_o_pwm;
    logic [DW-1:0]     r_o_duty;
    logic              r_o_on;
    logic              r_o_trip;
    logic              r_o_fade;
    logic [TRIP_W-1:0] r_o_cnt;

    logic [DW-1:0]     duty_sat;
    logic              trip_hit;
    logic [TIME_W-1:0] n_elapsed;
    logic              fade_end;
    logic              up;
    logic [DW-1:0]     diff;
    logic [MW-1:0]     prod;
    logic [PW-1:0]     dividend;
    logic [TIME_W:0]   rem_sh;
    logic              rem_ge;
    logic [DW-1:0]     quo;
    logic [DW-1:0]     n_duty_fin;
    logic [DW-1:0]     level;

    always_comb begin
        duty_sat  = (i_duty_level > FULL_SCALE) ? FULL_SCALE : i_duty_level;
        trip_hit  = !r_trip && ((i_current_ma >= r_fuse_ma) || (i_current_ma >= r_board_ma));
        n_elapsed = (r_elapsed != '1) ? r_elapsed + TIME_W'(1) : r_elapsed;
        fade_end  = (n_elapsed > r_total);

        // A falling fade rounds toward minus infinity, so the magnitude
        // is divided with rounding up.
        up       = (r_to >= r_from);
        diff     = up ? (r_to - r_from) : (r_from - r_to);
        prod     = MW'(r_elapsed) * MW'(diff);
        dividend = up ? PW'(prod) : (PW'(prod) + PW'(r_total) - PW'(1));

        rem_sh = {r_rem, r_quo[PW-1]};
        rem_ge = (rem_sh >= {1'b0, r_total});

        quo        = r_quo[DW-1:0];
        n_duty_fin = r_up ? (r_from + quo) : (r_from - quo);

        if (r_trip || !r_on) begin
            level = '0;
        end else if (!r_dimmable) begin
            level = FULL_SCALE;
        end else begin
            level = r_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimmable    <= 1'b1;
            r_fuse_ma     <= FUSE_RESET_MA;
            r_board_ma    <= FUSE_RESET_MA;
            r_duty        <= FULL_SCALE;
            r_on          <= 1'b0;
            r_trip        <= 1'b0;
            r_trip_cnt    <= '0;
            r_fade_active <= 1'b0;
            r_from        <= '0;
            r_to          <= '0;
            r_elapsed     <= '0;
            r_total       <= '0;
            r_interp      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DIMMABLE:  r_dimmable <= i_cfg_data[0];
                    CFG_SOFT_FUSE: r_fuse_ma  <= i_cfg_data;
                    CFG_BOARD_LIM: r_board_ma <= i_cfg_data;
                    default:       ;
                endcase
            end

            if (i_cmd.load) begin
                // Only a tick inside a running fade that does not end it needs the divider.
                r_interp <= (t_action'(i_action) == ACT_TICK) && r_fade_active && !fade_end;
                case (t_action'(i_action))
                    ACT_TICK: begin
                        // A fade that ends on this tick sets the on flag from its target, also after a trip.
                        if (trip_hit) begin
                            r_trip <= 1'b1;
                            if (!(r_fade_active && fade_end)) r_on <= 1'b0;
                            if (r_trip_cnt != '1) r_trip_cnt <= r_trip_cnt + TRIP_W'(1);
                        end
                        if (r_fade_active) begin
                            r_elapsed <= n_elapsed;
                            if (fade_end) begin
                                r_fade_active <= 1'b0;
                                r_duty        <= (r_to != '0) ? r_to : r_from;
                                r_on          <= (r_to != '0);
                            end
                        end
                    end
                    ACT_SET_DUTY: begin
                        r_duty <= duty_sat;
                    end
                    ACT_START_FADE: begin
                        if (!r_fade_active) begin
                            r_from        <= r_on ? r_duty : '0;
                            r_to          <= duty_sat;
                            r_elapsed     <= '0;
                            r_total       <= TIME_W'(i_fade_ms) + PAD;
                            r_on          <= 1'b1;
                            r_fade_active <= 1'b1;
                        end
                    end
                    default: begin
                        r_on <= i_switch_on;
                    end
                endcase
            end

            if (i_cmd.finish) begin
                r_duty <= n_duty_fin;
                r_on   <= (n_duty_fin != '0);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_up  <= up;
            r_quo <= dividend;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? TIME_W'(rem_sh - {1'b0, r_total}) : rem_sh[TIME_W-1:0];
            r_quo <= {r_quo[PW-2:0], rem_ge};
        end

        if (i_cmd.emit) begin
            r_o_pwm  <= level;
            r_o_duty <= r_duty;
            r_o_on   <= r_on;
            r_o_trip <= r_trip;
            r_o_fade <= r_fade_active;
            r_o_cnt  <= r_trip_cnt;
        end
    end

    assign o_stat.interp   = r_interp;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_pwm_level    = r_o_pwm;
    assign o_duty_now     = r_o_duty;
    assign o_channel_on   = r_o_on;
    assign o_fuse_tripped = r_o_trip;
    assign o_fade_busy    = r_o_fade;
    assign o_trip_total   = r_o_cnt;

    `PFC_ASSERT_NEXT(a_trip_sticky, i_clk, i_rst_n, r_trip, r_trip)
    `PFC_ASSERT_IMPL(a_trip_counted, i_clk, i_rst_n, r_trip, r_trip_cnt != '0)
    `PFC_ASSERT_IMPL(a_elapsed_in_range, i_clk, i_rst_n, r_fade_active, r_elapsed <= r_total)

endmodule

// ===== rtl/core/pwm_channel_fuse_fade_controller.sv =====
// A tick that interpolates a running fade passes through the multiply, the serial divide
// (one quotient bit per cycle) and the finish step before its result is stored.
// Every other item goes from evaluation straight to the result register.
// One item is in work at a time; input ready returns as the result is stored, and a
// result that finds the output register still full waits, holding input ready low.
// Reset (synchronous, active low) restores register defaults, full duty, off, no trip or fade.
// ----------------------------------------------------------------------------
// PWM channel fuse and fade controller
// One PWM load channel with duty, on flag, latched soft fuse and linear fade.
// ----------------------------------------------------------------------------
module pwm_channel_fuse_fade_controller
    import pfc_pkg::*;
#(
    parameter int DUTY_BITS   = 12,
    parameter int FADE_PAD_MS = 100
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfc_cfg_if.sink   i_cfg,
    pfc_in_if.sink    i_in,
    pfc_out_if.source o_out
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    pfc_ctrl #(
        .DUTY_BITS(DUTY_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    pfc_datapath #(
        .DUTY_BITS   (DUTY_BITS),
        .FADE_PAD_MS (FADE_PAD_MS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_action       (i_in.action),
        .i_current_ma   (i_in.current_ma),
        .i_duty_level   (i_in.duty_level),
        .i_fade_ms      (i_in.fade_ms),
        .i_switch_on    (i_in.switch_on),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_pwm_level    (o_out.pwm_level),
        .o_duty_now     (o_out.duty_now),
        .o_channel_on   (o_out.channel_on),
        .o_fuse_tripped (o_out.fuse_tripped),
        .o_fade_busy    (o_out.fade_busy),
        .o_trip_total   (o_out.trip_total)
    );

endmodule

// ===== tb/pfc_status_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM channel status checker
// Follows the configuration and input transfers of the channel controller,
// keeps its own copy of the channel state and compares every result transfer
// with the status predicted for the oldest input transfer still open.
// ----------------------------------------------------------------------------
module pfc_status_checker
    import pfc_pkg::*;
#(
    parameter int DUTY_BITS   = 12,
    parameter int FADE_PAD_MS = 100
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pfc_cfg_if   i_cfg,
    pfc_in_if    i_in,
    pfc_out_if   i_out,
    output int   o_error_count,
    output int   o_pending_count
);

    localparam int DUTY_W = DUTY_BITS + 1;
    localparam logic [DUTY_W-1:0] FULL_SCALE = DUTY_W'(1) << DUTY_BITS;

    typedef struct packed {
        logic [DUTY_W-1:0] pwm_level;
        logic [DUTY_W-1:0] duty_now;
        logic              channel_on;
        logic              fuse_tripped;
        logic              fade_busy;
        logic [TRIP_W-1:0] trip_total;
    } t_status;

    // Configuration copy
    logic                  dimmable_q;
    logic [CUR_W-1:0]      soft_fuse_q;
    logic [CUR_W-1:0]      board_limit_q;

    // Channel state copy
    logic [DUTY_W-1:0]     duty_q;
    logic                  on_q;
    logic                  trip_q;
    logic [TRIP_W-1:0]     trip_cnt_q;
    logic                  fading_q;
    logic [DUTY_W-1:0]     fade_from_q;
    logic [DUTY_W-1:0]     fade_to_q;
    logic [TIME_W-1:0]     fade_elapsed_q;
    logic [TIME_W-1:0]     fade_total_q;

    t_status status_queue[$];
    int      failures = 0;

    assign o_error_count = failures;

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    // Advances the channel copy by one accepted item and queues the status it must show.
    task automatic step_channel(input t_action act, input logic [CUR_W-1:0] cur,
                                input logic [DUTY_W-1:0] duty_raw,
                                input logic [FADE_MS_W-1:0] fms, input logic sw);
        logic [DUTY_W-1:0] duty_in;
        longint unsigned   span;
        longint unsigned   prod;
        t_status           status;
        duty_in = (duty_raw > FULL_SCALE) ? FULL_SCALE : duty_raw;
        case (act)
            ACT_TICK: begin
                if (!trip_q && (cur >= soft_fuse_q || cur >= board_limit_q)) begin
                    trip_q = 1'b1;
                    on_q   = 1'b0;
                    if (trip_cnt_q != '1)
                        trip_cnt_q++;
                end
                if (fading_q) begin
                    if (fade_elapsed_q != '1)
                        fade_elapsed_q++;
                    if (fade_elapsed_q > fade_total_q) begin
                        fading_q = 1'b0;
                        duty_q   = (fade_to_q != '0) ? fade_to_q : fade_from_q;
                        on_q     = (fade_to_q != '0);
                    end else begin
                        // Upward ramps round the step down, downward ramps round it up,
                        // so the level always lands on the floor of the exact line.
                        if (fade_to_q >= fade_from_q) begin
                            span   = 64'(fade_to_q) - 64'(fade_from_q);
                            prod   = 64'(fade_elapsed_q) * span;
                            duty_q = fade_from_q + DUTY_W'(prod / 64'(fade_total_q));
                        end else begin
                            span   = 64'(fade_from_q) - 64'(fade_to_q);
                            prod   = 64'(fade_elapsed_q) * span;
                            duty_q = fade_from_q - DUTY_W'((prod + 64'(fade_total_q) - 1)
                                                          / 64'(fade_total_q));
                        end
                        on_q = (duty_q != '0);
                    end
                end
            end
            ACT_SET_DUTY: begin
                duty_q = duty_in;
            end
            ACT_START_FADE: begin
                if (!fading_q) begin
                    fade_from_q    = on_q ? duty_q : '0;
                    fade_to_q      = duty_in;
                    fade_elapsed_q = '0;
                    fade_total_q   = TIME_W'(fms) + TIME_W'(FADE_PAD_MS);
                    on_q           = 1'b1;
                    fading_q       = 1'b1;
                end
            end
            ACT_SET_SWITCH: begin
                on_q = sw;
            end
            default: ;
        endcase

        if (trip_q || !on_q)
            status.pwm_level = '0;
        else if (!dimmable_q)
            status.pwm_level = FULL_SCALE;
        else
            status.pwm_level = duty_q;
        status.duty_now     = duty_q;
        status.channel_on   = on_q;
        status.fuse_tripped = trip_q;
        status.fade_busy    = fading_q;
        status.trip_total   = trip_cnt_q;
        status_queue.push_back(status);
    endtask

    always @(posedge i_clk) begin
        t_status seen;
        t_status want;
        if (!i_rst_n) begin
            dimmable_q     = 1'b1;
            soft_fuse_q    = FUSE_RESET_MA;
            board_limit_q  = FUSE_RESET_MA;
            duty_q         = FULL_SCALE;
            on_q           = 1'b0;
            trip_q         = 1'b0;
            trip_cnt_q     = '0;
            fading_q       = 1'b0;
            fade_from_q    = '0;
            fade_to_q      = '0;
            fade_elapsed_q = '0;
            fade_total_q   = '0;
            status_queue.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_DIMMABLE:  dimmable_q    = i_cfg.data[0];
                    CFG_SOFT_FUSE: soft_fuse_q   = i_cfg.data;
                    CFG_BOARD_LIM: board_limit_q = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                step_channel(t_action'(i_in.action), i_in.current_ma, i_in.duty_level,
                             i_in.fade_ms, i_in.switch_on);
            if (i_out.valid && i_out.ready) begin
                seen.pwm_level    = i_out.pwm_level;
                seen.duty_now     = i_out.duty_now;
                seen.channel_on   = i_out.channel_on;
                seen.fuse_tripped = i_out.fuse_tripped;
                seen.fade_busy    = i_out.fade_busy;
                seen.trip_total   = i_out.trip_total;
                if (status_queue.size() == 0) begin
                    $display("%0t: result transfer with no status pending, level %0d duty %0d",
                             $time, seen.pwm_level, seen.duty_now);
                    failures++;
                end else begin
                    want = status_queue.pop_front();
                    compare_field("pwm_level", 32'(want.pwm_level), 32'(seen.pwm_level));
                    compare_field("duty_now", 32'(want.duty_now), 32'(seen.duty_now));
                    compare_field("channel_on", 32'(want.channel_on), 32'(seen.channel_on));
                    compare_field("fuse_tripped", 32'(want.fuse_tripped),
                                  32'(seen.fuse_tripped));
                    compare_field("fade_busy", 32'(want.fade_busy), 32'(seen.fade_busy));
                    compare_field("trip_total", 32'(want.trip_total), 32'(seen.trip_total));
                end
            end
        end
        o_pending_count <= status_queue.size();
    end

endmodule

// ===== tb/pwm_channel_fuse_fade_controller_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM channel fuse and fade controller testbench
// Drives commands and millisecond ticks through the input channel in random
// bursts, stalls the result channel, steps the configuration through several
// settings between drained phases, and ends with a latched fuse trip.
// ----------------------------------------------------------------------------
module pwm_channel_fuse_fade_controller_test;
    import pfc_pkg::*;

    localparam int DUTY_BITS     = 12;
    localparam int FADE_PAD_MS   = 100;
    localparam int DUTY_W        = DUTY_BITS + 1;
    localparam logic [DUTY_W-1:0]    FULL_SCALE = DUTY_W'(1) << DUTY_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} t_rx_mode;
    typedef enum int {TRIP_SOFT_ZERO, TRIP_BOARD, TRIP_SOFT} t_trip_path;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    int       error_count;
    int       pending_count;
    int       cycle_count = 0;
    int       items_sent = 0;
    int       burst_left = 0;
    int       stall_left = 0;
    t_rx_mode stall_mode = RX_OPEN;

    pfc_cfg_if                    cfg_ch ();
    pfc_in_if  #(.DUTY_W(DUTY_W)) in_ch ();
    pfc_out_if #(.DUTY_W(DUTY_W)) out_ch ();

    pwm_channel_fuse_fade_controller #(
        .DUTY_BITS   (DUTY_BITS),
        .FADE_PAD_MS (FADE_PAD_MS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pfc_status_checker #(
        .DUTY_BITS   (DUTY_BITS),
        .FADE_PAD_MS (FADE_PAD_MS)
    ) u_status_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg_ch),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The result side switches between open, coin-flip, sparse and mostly blocked stretches.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_rx_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(10, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            RX_OPEN:   out_ch.ready <= 1'b1;
            RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   out_ch.ready <= (stall_left % 12 >= 9);
        endcase
    end

    function automatic logic [DUTY_W-1:0] pick_duty();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FULL_SCALE;
            2, 3:    return DUTY_W'($urandom_range(FULL_SCALE + 1, (1 << DUTY_W) - 1));
            default: return DUTY_W'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    function automatic logic [CUR_W-1:0] pick_current(input int unsigned cur_max);
        case ($urandom_range(0, 7))
            0:       return CUR_W'(cur_max);
            1:       return '0;
            default: return CUR_W'($urandom_range(0, cur_max));
        endcase
    endfunction

    // Called and left at a falling edge; valid stays high across back-to-back transfers.
    task automatic send_item(input t_action act, input logic [CUR_W-1:0] cur,
                             input logic [DUTY_W-1:0] duty, input logic [FADE_MS_W-1:0] fms,
                             input logic sw);
        int gap = 0;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 16);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.current_ma <= cur;
        in_ch.duty_level <= duty;
        in_ch.fade_ms    <= fms;
        in_ch.switch_on  <= sw;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Tick current is at most cur_max, fade time at most 40; other fields are random.
    task automatic send_noise(input int unsigned cur_max);
        t_action              act;
        logic [FADE_MS_W-1:0] fms;
        logic [CUR_W-1:0]     cur;
        act = t_action'($urandom_range(0, 3));
        fms = (act == ACT_START_FADE) ? FADE_MS_W'($urandom_range(0, 40)) : FADE_MS_W'($urandom);
        cur = (act == ACT_TICK) ? pick_current(cur_max) : CUR_W'($urandom);
        send_item(act, cur, pick_duty(), fms, 1'($urandom_range(0, 1)));
    endtask

    // A fade followed by enough ticks to run it out, with stray commands mixed in.
    task automatic run_fade(input int unsigned cur_max, input logic [FADE_MS_W-1:0] fms);
        int ticks;
        ticks = int'(fms) + FADE_PAD_MS + 1 + $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0)
            send_item(ACT_SET_SWITCH, CUR_W'($urandom), pick_duty(), FADE_MS_W'($urandom),
                      1'($urandom_range(0, 1)));
        send_item(ACT_START_FADE, CUR_W'($urandom), pick_duty(), fms, 1'($urandom_range(0, 1)));
        repeat (ticks) begin
            if ($urandom_range(0, 11) == 0)
                send_noise(cur_max);
            send_item(ACT_TICK, pick_current(cur_max), pick_duty(), FADE_MS_W'($urandom),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // A full fade is run only where its ticks fit in what is left of the phase.
    task automatic run_phase(input int items, input int unsigned cur_max);
        int start;
        int room;
        start = items_sent;
        while (items_sent - start < items) begin
            room = items - (items_sent - start) - FADE_PAD_MS - 4;
            case ($urandom_range(0, 9))
                0:       wait_drained();
                1, 2, 3: begin
                    if (room >= 0)
                        run_fade(cur_max, FADE_MS_W'($urandom_range(0, (room < 30) ? room : 30)));
                    else
                        send_noise(cur_max);
                end
                default: repeat ($urandom_range(1, 8)) send_noise(cur_max);
            endcase
        end
    endtask

    initial begin
        t_trip_path       trip_path;
        logic [CUR_W-1:0] trip_ma;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_DIMMABLE;
        cfg_ch.data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_TICK;
        in_ch.current_ma = '0;
        in_ch.duty_level = '0;
        in_ch.fade_ms    = '0;
        in_ch.switch_on  = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset configuration.
        send_item(ACT_TICK, 16'd0, FULL_SCALE, 16'd0, 1'b0);
        send_item(ACT_SET_SWITCH, 16'hFFFF, '0, 16'hFFFF, 1'b1);
        send_item(ACT_TICK, 16'd19999, '0, 16'd0, 1'b0);
        send_item(ACT_SET_DUTY, 16'd0, '0, 16'd0, 1'b0);
        send_item(ACT_SET_DUTY, 16'd0, '1, 16'd0, 1'b0);
        send_item(ACT_SET_DUTY, 16'd0, FULL_SCALE + DUTY_W'(1), 16'd0, 1'b0);
        send_item(ACT_SET_DUTY, 16'd0, 13'd1, 16'd0, 1'b0);
        send_item(ACT_SET_SWITCH, 16'd0, '0, 16'd0, 1'b0);
        // The fade starts from zero because the channel is off.
        send_item(ACT_START_FADE, 16'd0, '1, 16'd0, 1'b0);
        // A second start while the first still runs is dropped.
        send_item(ACT_START_FADE, 16'd0, 13'd100, 16'd5, 1'b0);
        send_item(ACT_TICK, 16'd100, '0, 16'd0, 1'b0);
        send_item(ACT_SET_DUTY, 16'd0, 13'd2000, 16'd0, 1'b0);
        send_item(ACT_TICK, 16'd0, '0, 16'd0, 1'b0);
        send_item(ACT_SET_SWITCH, 16'd0, '0, 16'd0, 1'b0);
        send_item(ACT_TICK, 16'd0, '0, 16'd0, 1'b1);

        write_register(CFG_SPARE, CFG_DATA_W'($urandom));
        write_register(CFG_DIMMABLE, 16'd1);
        write_register(CFG_SOFT_FUSE, 16'hFFFF);
        write_register(CFG_BOARD_LIM, 16'hFFFF);
        run_phase(140, 16'hFFFE);

        write_register(CFG_DIMMABLE, 16'd0);
        write_register(CFG_SOFT_FUSE, 16'd30000);
        write_register(CFG_BOARD_LIM, 16'd50000);
        run_phase(120, 29999);

        write_register(CFG_DIMMABLE, 16'd1);
        write_register(CFG_SOFT_FUSE, 16'hFFFF);
        write_register(CFG_BOARD_LIM, 16'd1);
        run_phase(60, 0);

        // The trip latches until reset, so it comes last, by one of three paths.
        trip_path = t_trip_path'($urandom_range(0, 2));
        trip_ma   = CUR_W'($urandom_range(1, 16'hFFFF));
        case (trip_path)
            TRIP_SOFT_ZERO: begin
                write_register(CFG_SOFT_FUSE, 16'd0);
                write_register(CFG_BOARD_LIM, 16'hFFFF);
                trip_ma = '0;
            end
            TRIP_BOARD: begin
                write_register(CFG_SOFT_FUSE, 16'hFFFF);
                write_register(CFG_BOARD_LIM, trip_ma);
            end
            default: begin
                write_register(CFG_SOFT_FUSE, trip_ma);
                write_register(CFG_BOARD_LIM, 16'hFFFF);
            end
        endcase
        send_item(ACT_TICK, trip_ma, pick_duty(), 16'd0, 1'b0);
        run_phase(30, 16'hFFFF);
        write_register(CFG_DIMMABLE, 16'd0);
        run_phase(30, 16'hFFFF);

        send_item(ACT_START_FADE, CUR_W'($urandom), pick_duty(),
                  FADE_MS_W'($urandom_range(32768, 65535)), 1'b1);
        repeat (3)
            send_item(ACT_TICK, CUR_W'($urandom), pick_duty(), FADE_MS_W'($urandom), 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
